### sv/lbm_pkg.sv
// Lorentz boost matrix package: request and result types, saturation helper.
// No dependencies; used by lorentz_boost_matrix, lbm_checker and the testbench.
package lbm_pkg;

  typedef struct packed {
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
  } in_req_t;

  typedef struct packed {
    logic               is_identity;
    logic signed [31:0] gamma_out;
    logic signed [31:0] boost_x;
    logic signed [31:0] boost_y;
    logic signed [31:0] boost_z;
    logic signed [31:0] m_xx;
    logic signed [31:0] m_yy;
    logic signed [31:0] m_zz;
    logic signed [31:0] m_xy;
    logic signed [31:0] m_xz;
    logic signed [31:0] m_yz;
  } out_res_t;

  localparam logic [63:0] POS_MAX = 64'd2147483647;
  localparam logic [63:0] NEG_MAX = 64'd2147483648;

  function automatic logic [31:0] sat32(input logic neg, input logic [63:0] mag);
    logic [63:0] m;
    m = mag;
    if (neg) begin
      if (m > NEG_MAX) m = NEG_MAX;
      return 32'(64'd0 - m);
    end
    if (m > POS_MAX) m = POS_MAX;
    return m[31:0];
  endfunction

endpackage

### sv/lorentz_boost_matrix.sv
// Lorentz boost matrix top level: input skid, products, square roots, dividers, output.
// Depends on lbm_pkg, lbm_delay, lbm_isqrt, lbm_div.
//
// Takes one velocity request per cycle while the output is not stalled and returns the
// ten distinct entries of the 4x4 boost matrix, in order.
// The path runs through the bit-per-stage square roots of |v|^2 and 1-beta^2 and the
// bit-per-stage divider for gamma. A one-entry input skid keeps one request accepted
// while a result waits. Write inv_light_speed only while the block is empty.
module lorentz_boost_matrix #(
  parameter int FRACTION_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [31:0]      cfg_wr_data,
  input  logic             in_valid,
  output logic             in_ready,
  input  lbm_pkg::in_req_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output lbm_pkg::out_res_t out_data
);

  localparam int F  = FRACTION_BITS;
  localparam int LG = 3*F + 39;
  localparam logic [31:0]  ONE    = 32'd1 << F;
  localparam logic [F+1:0] TWO    = {2'b10, {F{1'b0}}};
  localparam logic [F+1:0] ONE_S  = {2'b01, {F{1'b0}}};
  localparam logic [2*F:0] ONE_SQ = {1'b1, {(2*F){1'b0}}};

  logic en;
  logic [31:0] ci_r;

  always_ff @(posedge clk) begin
    if (!rst_n) ci_r <= '0;
    else if (cfg_wr_en) ci_r <= cfg_wr_data;
  end

  // input skid
  logic             skid_v_r;
  lbm_pkg::in_req_t skid_d_r;
  lbm_pkg::in_req_t src;
  logic             src_v;

  assign in_ready = !skid_v_r;
  assign src      = skid_v_r ? skid_d_r : in_data;
  assign src_v    = skid_v_r || in_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_v_r <= 1'b0;
    end else if (en) begin
      skid_v_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!en && in_valid && in_ready) skid_d_r <= in_data;
  end

  // stage 1: magnitudes and signs
  logic [31:0] vel [3];
  logic [31:0] mag1_r [3];
  logic [2:0]  neg1_r;
  logic        v1_r;

  assign vel[0] = src.vel_x;
  assign vel[1] = src.vel_y;
  assign vel[2] = src.vel_z;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mag1_r[i] <= vel[i][31] ? (~vel[i] + 32'd1) : vel[i];
        neg1_r[i] <= vel[i][31];
      end
    end
  end

  // stage 2: squares, cross products, scaled components
  logic [63:0] sq2_r [3];
  logic [63:0] cr2_r [3];
  logic [31:0] w2_r  [3];
  logic [63:0] wp    [3];
  logic [2:0]  neg2_r;
  logic [2:0]  nz2_r;
  logic        v2_r;

  always_comb begin
    for (int i = 0; i < 3; i++) wp[i] = {32'd0, mag1_r[i]} * {32'd0, ci_r};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        sq2_r[i] <= {32'd0, mag1_r[i]} * {32'd0, mag1_r[i]};
        w2_r[i]  <= wp[i][63:32];
        nz2_r[i] <= mag1_r[i] != 32'd0;
      end
      cr2_r[0] <= {32'd0, mag1_r[0]} * {32'd0, mag1_r[1]};
      cr2_r[1] <= {32'd0, mag1_r[0]} * {32'd0, mag1_r[2]};
      cr2_r[2] <= {32'd0, mag1_r[1]} * {32'd0, mag1_r[2]};
      neg2_r   <= neg1_r;
    end
  end

  // stage 3: |v|^2
  logic [63:0] vv3_r;
  logic [63:0] sq3_r [3];
  logic [63:0] cr3_r [3];
  logic [31:0] w3_r  [3];
  logic [2:0]  neg3_r;
  logic [2:0]  nz3_r;
  logic        v3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      vv3_r  <= sq2_r[0] + sq2_r[1] + sq2_r[2];
      sq3_r  <= sq2_r;
      cr3_r  <= cr2_r;
      w3_r   <= w2_r;
      neg3_r <= neg2_r;
      nz3_r  <= nz2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= src_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // gamma chain
  logic [31:0] vroot;
  logic [63:0] bp;
  logic [31:0] beta_r;
  logic        vzero_r;

  lbm_isqrt #(.IW(64)) u_vsqrt (.clk(clk), .en(en), .x(vv3_r), .root(vroot));

  assign bp = {32'd0, vroot} * {32'd0, ci_r};

  always_ff @(posedge clk) begin
    if (en) begin
      beta_r  <= bp[63:32];
      vzero_r <= vroot == 32'd0;
    end
  end

  logic [31:0]  beta_m1;
  logic [F+1:0] tmod;
  logic [F+1:0] folded;
  logic [F+1:0] betaf;
  logic [F+1:0] betaf_r;
  logic         identf_r;

  assign beta_m1 = beta_r - ONE;
  assign tmod    = beta_m1[F+1:0];
  assign folded  = (tmod >= TWO) ? (tmod - TWO) : (TWO - tmod);
  assign betaf   = (beta_r > ONE) ? folded : beta_r[F+1:0];

  always_ff @(posedge clk) begin
    if (en) begin
      betaf_r  <= betaf;
      identf_r <= vzero_r || (betaf >= ONE_S);
    end
  end

  logic [2*F-1:0] bsq_r;
  logic [2*F:0]   d_r;

  always_ff @(posedge clk) begin
    if (en) begin
      bsq_r <= (2*F)'(betaf_r[F-1:0]) * (2*F)'(betaf_r[F-1:0]);
      d_r   <= ONE_SQ - {1'b0, bsq_r};
    end
  end

  logic [F:0]   sroot;
  logic [2*F:0] gq;

  lbm_isqrt #(.IW(2*F+2)) u_dsqrt (.clk(clk), .en(en), .x({1'b0, d_r}), .root(sroot));

  lbm_div #(.DW(F+1), .K(2*F)) u_gdiv (
    .clk(clk), .en(en), .num((F+1)'(1)), .den(sroot), .quo(gq)
  );

  logic [63:0] gq64;
  logic [31:0] gclamp;
  logic [31:0] gamma_r;
  logic [31:0] g1_r;

  assign gq64   = 64'(gq);
  assign gclamp = (gq64 > lbm_pkg::POS_MAX) ? lbm_pkg::POS_MAX[31:0] : gq64[31:0];

  always_ff @(posedge clk) begin
    if (en) begin
      gamma_r <= gclamp;
      g1_r    <= gclamp - ONE;
    end
  end

  logic ident_g;

  lbm_delay #(.W(1), .D(3*F+5)) u_ident_dly (
    .clk(clk), .rst_n(rst_n), .en(en), .d(identf_r), .q(ident_g)
  );

  // ratios vi*vj/|v|^2
  logic [F:0]       rq [6];
  logic [6*F+5:0]   rq_bus;
  logic [6*F+5:0]   rq_g;

  generate
    for (genvar j = 0; j < 3; j++) begin : g_ratio
      lbm_div #(.DW(64), .K(F)) u_dd (
        .clk(clk), .en(en), .num(sq3_r[j]), .den(vv3_r), .quo(rq[j])
      );
      lbm_div #(.DW(64), .K(F)) u_dx (
        .clk(clk), .en(en), .num(cr3_r[j]), .den(vv3_r), .quo(rq[j+3])
      );
    end
  endgenerate

  assign rq_bus = {rq[5], rq[4], rq[3], rq[2], rq[1], rq[0]};

  lbm_delay #(.W(6*F+6), .D(2*F+38)) u_ratio_dly (
    .clk(clk), .rst_n(rst_n), .en(en), .d(rq_bus), .q(rq_g)
  );

  // side data and valid alignment
  logic [101:0] side_g;
  logic         vg;

  lbm_delay #(.W(102), .D(LG)) u_side_dly (
    .clk(clk), .rst_n(rst_n), .en(en),
    .d({w3_r[2], w3_r[1], w3_r[0], neg3_r, nz3_r}), .q(side_g)
  );

  lbm_delay #(.W(1), .D(LG), .CLR(1'b1)) u_valid_dly (
    .clk(clk), .rst_n(rst_n), .en(en), .d(v3_r), .q(vg)
  );

  // final products
  logic [61:0]    bm_r [3];
  logic [F+31:0]  tp_r [6];
  logic [31:0]    gm_r;
  logic [2:0]     negm_r;
  logic [2:0]     nzm_r;
  logic           identm_r;
  logic           vm_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        bm_r[i] <= 62'(gamma_r[30:0]) * 62'(side_g[6+32*i +: 31]);
      end
      for (int j = 0; j < 6; j++) begin
        tp_r[j] <= (F+32)'(g1_r[30:0]) * (F+32)'(rq_g[(F+1)*j +: F+1]);
      end
      gm_r     <= gamma_r;
      negm_r   <= side_g[5:3];
      nzm_r    <= side_g[2:0];
      identm_r <= ident_g;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) vm_r <= 1'b0;
    else if (en) vm_r <= vg;
  end

  // saturate and select identity
  lbm_pkg::out_res_t res;
  lbm_pkg::out_res_t out_data_r;
  logic              out_valid_r;
  logic [63:0]       tm [6];
  logic [63:0]       bmag [3];

  always_comb begin
    for (int i = 0; i < 3; i++) bmag[i] = 64'(bm_r[i] >> F);
    for (int j = 0; j < 6; j++) tm[j] = 64'(tp_r[j] >> F);
    res.is_identity = 1'b0;
    res.gamma_out   = gm_r;
    res.boost_x     = lbm_pkg::sat32(!negm_r[0] && nzm_r[0], bmag[0]);
    res.boost_y     = lbm_pkg::sat32(!negm_r[1] && nzm_r[1], bmag[1]);
    res.boost_z     = lbm_pkg::sat32(!negm_r[2] && nzm_r[2], bmag[2]);
    res.m_xx        = lbm_pkg::sat32(1'b0, 64'(ONE) + tm[0]);
    res.m_yy        = lbm_pkg::sat32(1'b0, 64'(ONE) + tm[1]);
    res.m_zz        = lbm_pkg::sat32(1'b0, 64'(ONE) + tm[2]);
    res.m_xy        = lbm_pkg::sat32(negm_r[0] ^ negm_r[1], tm[3]);
    res.m_xz        = lbm_pkg::sat32(negm_r[0] ^ negm_r[2], tm[4]);
    res.m_yz        = lbm_pkg::sat32(negm_r[1] ^ negm_r[2], tm[5]);
    if (identm_r) begin
      res.is_identity = 1'b1;
      res.gamma_out   = ONE;
      res.boost_x     = '0;
      res.boost_y     = '0;
      res.boost_z     = '0;
      res.m_xx        = ONE;
      res.m_yy        = ONE;
      res.m_zz        = ONE;
      res.m_xy        = '0;
      res.m_xz        = '0;
      res.m_yz        = '0;
    end
  end

  assign en = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= vm_r;
  end

  always_ff @(posedge clk) begin
    if (en) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTH
  a_ident_gamma: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.is_identity |-> out_data.gamma_out == $signed(ONE))
    else $error("identity result without unit gamma");

  a_gamma_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_identity |-> out_data.gamma_out >= $signed(ONE))
    else $error("gamma below one");

  a_diag_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.is_identity |->
      out_data.m_xx >= $signed(ONE) && out_data.m_yy >= $signed(ONE) &&
      out_data.m_zz >= $signed(ONE))
    else $error("diagonal entry below one");

  a_skid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    skid_v_r && !en |=> skid_v_r)
    else $error("skid request dropped during stall");
`endif

endmodule

### sv/lbm_delay.sv
// Enabled shift register that aligns side data with the arithmetic stages.
// Depends on nothing; CLR selects a cleared (control) line.
module lbm_delay #(
  parameter int W   = 1,
  parameter int D   = 1,
  parameter bit CLR = 1'b0
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] pipe_r [D];

  generate
    if (CLR) begin : g_clr
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          for (int k = 0; k < D; k++) pipe_r[k] <= '0;
        end else if (en) begin
          pipe_r[0] <= d;
          for (int k = 1; k < D; k++) pipe_r[k] <= pipe_r[k-1];
        end
      end
    end else begin : g_plain
      always_ff @(posedge clk) begin
        if (en) begin
          pipe_r[0] <= d;
          for (int k = 1; k < D; k++) pipe_r[k] <= pipe_r[k-1];
        end
      end
    end
  endgenerate

  assign q = pipe_r[D-1];

endmodule

### sv/lbm_isqrt.sv
// Pipelined integer square root, one result bit per stage (floor sqrt).
// Depends on nothing.
module lbm_isqrt #(
  parameter int IW = 64
) (
  input  logic            clk,
  input  logic            en,
  input  logic [IW-1:0]   x,
  output logic [IW/2-1:0] root
);

  localparam int H = IW / 2;

  logic [IW-1:0] x_r    [H];
  logic [H:0]    rem_r  [H];
  logic [H-1:0]  root_r [H];

  generate
    for (genvar k = 0; k < H; k++) begin : g_step
      logic [IW-1:0] x_in;
      logic [H:0]    rem_in;
      logic [H-1:0]  root_in;
      logic [H+2:0]  acc;
      logic [H+2:0]  trial;
      logic [H+2:0]  diff;
      logic          take;

      if (k == 0) begin : g_first
        assign x_in    = x;
        assign rem_in  = '0;
        assign root_in = '0;
      end else begin : g_next
        assign x_in    = x_r[k-1];
        assign rem_in  = rem_r[k-1];
        assign root_in = root_r[k-1];
      end

      assign acc   = {rem_in, x_in[IW-1 -: 2]};
      assign trial = {1'b0, root_in, 2'b01};
      assign diff  = acc - trial;
      assign take  = acc >= trial;

      always_ff @(posedge clk) begin
        if (en) begin
          x_r[k]    <= x_in << 2;
          rem_r[k]  <= take ? diff[H:0] : acc[H:0];
          root_r[k] <= {root_in[H-2:0], take};
        end
      end
    end
  endgenerate

  assign root = root_r[H-1];

endmodule

### sv/lbm_div.sv
// Pipelined restoring divider: q = floor(num * 2^K / den) for num < 2*den.
// Depends on nothing.
module lbm_div #(
  parameter int DW = 64,
  parameter int K  = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [K:0]    quo
);

  logic [DW-1:0] rem_r [K+1];
  logic [DW-1:0] den_r [K+1];
  logic [K:0]    q_r   [K+1];

  generate
    for (genvar k = 0; k <= K; k++) begin : g_step
      logic [DW:0]   r2;
      logic [DW:0]   dext;
      logic [DW:0]   diff;
      logic [DW-1:0] dsel;
      logic [K:0]    qin;
      logic          ge;

      if (k == 0) begin : g_first
        assign r2   = {1'b0, num};
        assign dsel = den;
        assign qin  = '0;
      end else begin : g_next
        assign r2   = {rem_r[k-1], 1'b0};
        assign dsel = den_r[k-1];
        assign qin  = q_r[k-1];
      end

      assign dext = {1'b0, dsel};
      assign diff = r2 - dext;
      assign ge   = r2 >= dext;

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? diff[DW-1:0] : r2[DW-1:0];
          den_r[k] <= dsel;
          q_r[k]   <= {qin[K-1:0], ge};
        end
      end
    end
  endgenerate

  assign quo = q_r[K];

endmodule

### sim/lbm_checker.sv
// Checker for the Lorentz boost matrix: watches both channels, predicts each result.
// Depends on lbm_pkg; instantiated by tb_lorentz_boost_matrix beside the block.
module lbm_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [31:0]       cfg_wr_data,
  input  logic              in_valid,
  input  logic              in_ready,
  input  lbm_pkg::in_req_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  lbm_pkg::out_res_t out_data,
  output int                fail_count,
  output int                pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = 16;
  localparam logic [63:0] ONE = 64'd1 << FB;

  logic [31:0]       inv_c;
  lbm_pkg::out_res_t matrix_q[$];

  function automatic logic [63:0] root64(input logic [63:0] x);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] frac_of(input logic [63:0] p, input logic [63:0] d);
    logic [127:0] n;
    n = {64'd0, p} << FB;
    return 64'(n / {64'd0, d});
  endfunction

  function automatic logic [31:0] clip(input logic neg, input logic [63:0] mag);
    logic [63:0] m;
    m = mag;
    if (neg) begin
      if (m > 64'd2147483648) m = 64'd2147483648;
      return 32'(64'd0 - m);
    end
    if (m > 64'd2147483647) m = 64'd2147483647;
    return m[31:0];
  endfunction

  function automatic lbm_pkg::out_res_t boost_matrix(input lbm_pkg::in_req_t v,
                                                     input logic [31:0] ci);
    lbm_pkg::out_res_t r;
    logic [31:0] comp[3];
    logic [63:0] mag[3];
    logic        neg[3];
    logic [63:0] vv, beta, t, s, gam, g1, w, m, q;
    logic [127:0] prod;
    int          a, b;
    comp[0] = v.vel_x;
    comp[1] = v.vel_y;
    comp[2] = v.vel_z;
    for (int i = 0; i < 3; i++) begin
      neg[i] = comp[i][31];
      mag[i] = neg[i] ? {32'd0, 32'd0 - comp[i]} : {32'd0, comp[i]};
    end
    vv = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
    beta = 0;
    if (vv != 0) begin
      prod = root64(vv) * {32'd0, ci};
      beta = 64'(prod >> 32);
      if (beta > ONE) begin
        t = (beta - ONE) % (4 * ONE);
        beta = (t >= 2 * ONE) ? t - 2 * ONE : 2 * ONE - t;
      end
    end
    if (vv == 0 || beta >= ONE) begin
      r = '0;
      r.is_identity = 1'b1;
      r.gamma_out = ONE[31:0];
      r.m_xx = ONE[31:0];
      r.m_yy = ONE[31:0];
      r.m_zz = ONE[31:0];
      return r;
    end
    s = root64(ONE * ONE - beta * beta);
    if (s == 0) s = 1;
    gam = (ONE * ONE) / s;
    if (gam > 64'd2147483647) gam = 64'd2147483647;
    g1 = (gam >= ONE) ? gam - ONE : 0;
    r.is_identity = 1'b0;
    r.gamma_out = gam[31:0];
    for (int i = 0; i < 3; i++) begin
      w = (mag[i] * {32'd0, ci}) >> 32;
      m = (gam * w) >> FB;
      comp[i] = clip(!neg[i] && mag[i] != 0, m);
    end
    r.boost_x = comp[0];
    r.boost_y = comp[1];
    r.boost_z = comp[2];
    for (int i = 0; i < 3; i++) begin
      q = frac_of(mag[i] * mag[i], vv);
      comp[i] = clip(1'b0, ONE + ((g1 * q) >> FB));
    end
    r.m_xx = comp[0];
    r.m_yy = comp[1];
    r.m_zz = comp[2];
    for (int i = 0; i < 3; i++) begin
      a = (i == 2) ? 1 : 0;
      b = (i == 0) ? 1 : 2;
      q = frac_of(mag[a] * mag[b], vv);
      comp[i] = clip(neg[a] != neg[b], (g1 * q) >> FB);
    end
    r.m_xy = comp[0];
    r.m_xz = comp[1];
    r.m_yz = comp[2];
    return r;
  endfunction

  task automatic cmp(input string name, input logic [31:0] exp_v, input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, got %h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    lbm_pkg::out_res_t e;
    if (!rst_n) begin
      inv_c <= '0;
      fail_count = 0;
      matrix_q.delete();
      pending <= 0;
    end else begin
      if (cfg_wr_en) inv_c <= cfg_wr_data;
      if (in_valid && in_ready) matrix_q.push_back(boost_matrix(in_data, inv_c));
      if (out_valid && out_ready) begin
        if (matrix_q.size() == 0) begin
          $error("unexpected result %h", out_data);
          fail_count++;
        end else begin
          e = matrix_q.pop_front();
          cmp("is_identity", {31'd0, e.is_identity}, {31'd0, out_data.is_identity});
          cmp("gamma_out", e.gamma_out, out_data.gamma_out);
          cmp("boost_x", e.boost_x, out_data.boost_x);
          cmp("boost_y", e.boost_y, out_data.boost_y);
          cmp("boost_z", e.boost_z, out_data.boost_z);
          cmp("m_xx", e.m_xx, out_data.m_xx);
          cmp("m_yy", e.m_yy, out_data.m_yy);
          cmp("m_zz", e.m_zz, out_data.m_zz);
          cmp("m_xy", e.m_xy, out_data.m_xy);
          cmp("m_xz", e.m_xz, out_data.m_xz);
          cmp("m_yz", e.m_yz, out_data.m_yz);
        end
      end
      pending <= matrix_q.size();
    end
  end
endmodule

### sim/tb_lorentz_boost_matrix.sv
// Testbench top for lorentz_boost_matrix: clock, reset, requests, register writes, verdict.
// Depends on lbm_pkg, lorentz_boost_matrix and lbm_checker.
module tb_lorentz_boost_matrix;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG    = 2000;
  localparam int HOLD_CYCLES = 300;

  logic              clk = 0;
  logic              rst_n = 0;
  logic              cfg_wr_en = 0;
  logic [31:0]       cfg_wr_data = '0;
  logic              in_valid = 0;
  logic              in_ready;
  lbm_pkg::in_req_t  in_data = '0;
  logic              out_valid;
  logic              out_ready = 0;
  lbm_pkg::out_res_t out_data;
  int                fail_count;
  int                pending;
  int                idle_pct = 26;
  bit                no_idle = 1'b0;
  bit                rx_hold_go = 1'b0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  lorentz_boost_matrix dut (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  lbm_checker u_check (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  function automatic lbm_pkg::in_req_t next_req();
    lbm_pkg::in_req_t q;
    logic [31:0]      c [3];
    int               pick;
    int               axis;
    pick = $urandom_range(0, 99);
    axis = $urandom_range(0, 2);
    for (int i = 0; i < 3; i++) c[i] = $urandom();
    if (pick < 6) begin
      for (int i = 0; i < 3; i++) c[i] = '0;
    end else if (pick < 60) begin
      for (int i = 0; i < 3; i++) c[i] = {{11{c[i][20]}}, c[i][20:0]};
    end else if (pick < 75) begin
      for (int i = 0; i < 3; i++) begin
        if (i != axis) c[i] = '0;
      end
      if (pick < 65) c[axis] = 32'h8000_0000;
    end
    q.vel_x = c[0];
    q.vel_y = c[1];
    q.vel_z = c[2];
    return q;
  endfunction

  task automatic send_items(input int n);
    int sent;
    int offered;
    sent = 0;
    offered = 0;
    while (sent < n) begin
      @(posedge clk);
      if (in_valid && in_ready) sent++;
      if (!in_valid || in_ready) begin
        if (offered < n && (no_idle || $urandom_range(0, 99) >= idle_pct)) begin
          in_valid <= 1'b1;
          in_data  <= next_req();
          offered++;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  endtask

  task automatic drain();
    @(posedge clk);
    wait (pending == 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [31:0] val);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= val;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // receiver: random idling, or a counted hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rx_hold_go) begin
        hold_left  = HOLD_CYCLES;
        rx_hold_go = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= no_idle || ($urandom_range(0, 99) >= idle_pct);
      end
    end
  end

  // watchdog: end the run after too many cycles without progress
  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_wr_en) quiet = 0;
      else quiet++;
      if (quiet >= WATCHDOG) begin
        $error("no progress for %0d cycles", WATCHDOG);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);
    write_cfg(32'd0);
    send_items(60);
    drain();
    write_cfg(32'h0600_0000);
    send_items(120);
    no_idle = 1'b1;
    send_items(80);
    no_idle = 1'b0;
    drain();
    write_cfg(32'h0c00_0000);
    rx_hold_go = 1'b1;
    send_items(120);
    drain();
    write_cfg($urandom());
    send_items(90);
    drain();
    write_cfg(32'h0400_0000 | ($urandom() & 32'h03ff_ffff));
    send_items(80);
    drain();
    if (fail_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
